@@ src/complex_number_alu_top_defines.svh @@
// Assertion macros used by the port-level checker of the complex number ALU
`ifndef COMPLEX_NUMBER_ALU_TOP_DEFINES_SVH
`define COMPLEX_NUMBER_ALU_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CNA_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CNA_ASSERT_NXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ src/cna_pkg.sv @@
// Shared constants, types and tables of the complex number ALU
package cna_pkg;

   localparam int IN_W     = 16;
   localparam int OUT_W    = 32;
   localparam int IN_FRAC  = IN_W / 2;
   localparam int OUT_FRAC = OUT_W / 2;

   localparam int PROD_W = 2 * IN_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int DEN_W  = PROD_W;
   localparam int NUM_W  = DEN_W + OUT_FRAC;
   localparam int DIV_LAT = NUM_W + 1;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
   localparam int CW = IN_W + OUT_FRAC + 3;
   localparam int ZW = 20;
   localparam logic signed [ZW-1:0] HALF_PI = ZW'(102944);

   localparam int RAD_W    = DEN_W + 2 * (OUT_FRAC - IN_FRAC);
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 2;
   localparam int SQRT_LAT = ROOT_W;

   typedef enum logic [2:0] {
      FN_ADD = 3'd0,
      FN_SUB = 3'd1,
      FN_MUL = 3'd2,
      FN_DIV = 3'd3,
      FN_ARG = 3'd4,
      FN_MOD = 3'd5
   } func_type;

   // atan(2^-i) in signed Q4.16
   function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_IDX_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         4'd0:    v = ZW'(51472);
         4'd1:    v = ZW'(30386);
         4'd2:    v = ZW'(16055);
         4'd3:    v = ZW'(8150);
         4'd4:    v = ZW'(4091);
         4'd5:    v = ZW'(2047);
         4'd6:    v = ZW'(1024);
         4'd7:    v = ZW'(512);
         4'd8:    v = ZW'(256);
         4'd9:    v = ZW'(128);
         4'd10:   v = ZW'(64);
         4'd11:   v = ZW'(32);
         4'd12:   v = ZW'(16);
         4'd13:   v = ZW'(8);
         4'd14:   v = ZW'(4);
         default: v = ZW'(2);
      endcase
      return v;
   endfunction

endpackage

@@ src/cna_if.sv @@
// Request and response channel interfaces of the complex number ALU
interface cna_req_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          func;
   logic signed [cna_pkg::IN_W-1:0]     a_real;
   logic signed [cna_pkg::IN_W-1:0]     a_imag;
   logic signed [cna_pkg::IN_W-1:0]     b_real;
   logic signed [cna_pkg::IN_W-1:0]     b_imag;

   modport source (output valid, func, a_real, a_imag, b_real, b_imag, input ready);
   modport sink (input valid, func, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cna_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cna_pkg::OUT_W-1:0]    res_real;
   logic signed [cna_pkg::OUT_W-1:0]    res_imag;
   logic                                div_error;
   logic                                overflow;

   modport source (output valid, res_real, res_imag, div_error, overflow, input ready);
   modport sink (input valid, res_real, res_imag, div_error, overflow, output ready);
endinterface

@@ src/cna_divider.sv @@
// Pipelined restoring divider, two quotient lanes sharing one divisor
module cna_divider (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [cna_pkg::SUM_W-1:0] num_re,
   input  logic signed [cna_pkg::SUM_W-1:0] num_im,
   input  logic [cna_pkg::DEN_W-1:0]       den,
   output logic [cna_pkg::NUM_W-1:0]       quo_re,
   output logic [cna_pkg::NUM_W-1:0]       quo_im
);
   import cna_pkg::*;

   // w shifts the dividend out at the top and the quotient in at the bottom
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [NUM_W-1:0] w;
   } div_lane_type;

   div_lane_type     lre_ff [DIV_LAT];
   div_lane_type     lim_ff [DIV_LAT];
   logic [DEN_W-1:0] den_ff [DIV_LAT-1];

   function automatic logic [NUM_W-1:0] scaled_mag(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] mag;
      mag = v[SUM_W-1] ? -v : v;
      return {mag[DEN_W-1:0], {OUT_FRAC{1'b0}}};
   endfunction

   function automatic div_lane_type div_step(input div_lane_type s, input logic [DEN_W-1:0] d);
      logic [DEN_W:0] t;
      logic           ge;
      div_lane_type   o;
      t = {s.rem, s.w[NUM_W-1]};
      ge = (t >= {1'b0, d});
      o.rem = ge ? DEN_W'(t - {1'b0, d}) : t[DEN_W-1:0];
      o.w = {s.w[NUM_W-2:0], ge};
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         lre_ff[0] <= '{rem: '0, w: scaled_mag(num_re)};
         lim_ff[0] <= '{rem: '0, w: scaled_mag(num_im)};
         den_ff[0] <= den;
      end
   end

   for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            lre_ff[k] <= div_step(lre_ff[k-1], den_ff[k-1]);
            lim_ff[k] <= div_step(lim_ff[k-1], den_ff[k-1]);
         end
      end
      if (k < DIV_LAT - 1) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[k] <= den_ff[k-1];
            end
         end
      end
   end

   assign quo_re = lre_ff[DIV_LAT-1].w;
   assign quo_im = lim_ff[DIV_LAT-1].w;

endmodule

@@ src/cna_cordic.sv @@
// Pipelined vectoring CORDIC giving the argument of a complex value
module cna_cordic (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [cna_pkg::IN_W-1:0] a_re,
   input  logic signed [cna_pkg::IN_W-1:0] a_im,
   output logic signed [cna_pkg::ZW-1:0]   angle
);
   import cna_pkg::*;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [ZW-1:0] z;
   } cor_type;

   cor_type cor_ff [CORDIC_LAT];

   // left half plane is turned by +-pi/2 first
   function automatic cor_type pre_rotate(input logic signed [IN_W-1:0] re,
                                          input logic signed [IN_W-1:0] im);
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      cor_type              o;
      xs = CW'(re) <<< OUT_FRAC;
      ys = CW'(im) <<< OUT_FRAC;
      if (xs < 0) begin
         if (ys >= 0) begin
            o.x = ys;
            o.y = -xs;
            o.z = HALF_PI;
         end else begin
            o.x = -ys;
            o.y = xs;
            o.z = -HALF_PI;
         end
      end else begin
         o.x = xs;
         o.y = ys;
         o.z = '0;
      end
      return o;
   endfunction

   function automatic cor_type cor_step(input cor_type s, input logic [STEP_IDX_W-1:0] i);
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      cor_type              o;
      x = s.x;
      y = s.y;
      z = s.z;
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
         o.x = x + dx;
         o.y = y - dy;
         o.z = z + atan_q16(i);
      end else begin
         o.x = x - dx;
         o.y = y + dy;
         o.z = z - atan_q16(i);
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         cor_ff[0] <= pre_rotate(a_re, a_im);
      end
   end

   for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            cor_ff[k] <= cor_step(cor_ff[k-1], STEP_IDX_W'(k - 1));
         end
      end
   end

   assign angle = cor_ff[CORDIC_LAT-1].z;

endmodule

@@ src/cna_isqrt.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage
module cna_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cna_pkg::DEN_W-1:0]     mag2,
   output logic [cna_pkg::ROOT_W-1:0]    root
);
   import cna_pkg::*;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_type;

   sq_type sq_ff [SQRT_LAT];

   function automatic sq_type sq_step(input sq_type s);
      logic [REM_W+1:0] t;
      logic [REM_W+1:0] trial;
      logic             ge;
      sq_type           o;
      t = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({s.root, 2'b01});
      ge = (t >= trial);
      o.rem = ge ? REM_W'(t - trial) : t[REM_W-1:0];
      o.root = {s.root[ROOT_W-2:0], ge};
      o.rad = s.rad << 2;
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= sq_step('{rad: {mag2, {(RAD_W - DEN_W){1'b0}}}, rem: '0, root: '0});
      end
   end

   for (genvar k = 1; k < SQRT_LAT; k++) begin : g_digit
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[k] <= sq_step(sq_ff[k-1]);
         end
      end
   end

   assign root = sq_ff[SQRT_LAT-1].root;

endmodule

@@ src/complex_number_alu_top.sv @@
// A request passes the capture, product and sum stages, the long units and the output register.
// Throughput: one request per cycle while the output is not stalled; the restoring divider sets the depth.
// The whole pipeline advances together; it holds only while the output waits.
// Reset (synchronous) clears all valid bits; no clearing pass, ready right after.
// Argument via 16-step CORDIC, modulus via 24-stage square root, padded to align.
module complex_number_alu_top (
   input  logic     clock,
   input  logic     reset,
   cna_req_if.sink   req_ch,
   cna_rsp_if.source rsp_ch
);
   import cna_pkg::*;

   localparam int VLD_N  = DIV_LAT + 3;
   localparam int COR_PAD = DIV_LAT - CORDIC_LAT;
   localparam int SQ_PAD  = DIV_LAT - SQRT_LAT;

   typedef struct packed {
      logic [2:0]              func;
      logic                    den_zero;
      logic                    a_zero;
      logic                    nr_neg;
      logic                    ni_neg;
      logic signed [IN_W:0]    as_re;
      logic signed [IN_W:0]    as_im;
      logic signed [SUM_W-1:0] mul_re;
      logic signed [SUM_W-1:0] mul_im;
   } side_type;

   typedef struct packed {
      logic             ovf;
      logic [OUT_W-1:0] val;
   } sat_type;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   logic adv;
   logic vld_ff [VLD_N];

   // stage 1: request capture
   logic [2:0]             func1_ff;
   logic signed [IN_W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // stage 2: products
   logic [2:0]               func2_ff;
   logic signed [IN_W-1:0]   ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PROD_W-1:0] d_r_ff, d_i_ff, m_r_ff, m_i_ff;

   // stage 3: sums, feeding the long units
   logic signed [SUM_W-1:0] nr3_ff, ni3_ff;
   logic [DEN_W-1:0]        den3_ff, mag3_ff;
   logic signed [IN_W-1:0]  ar3_ff, ai3_ff;
   side_type                side_ff [DIV_LAT+1];

   logic [NUM_W-1:0]     quo_re, quo_im;
   logic signed [ZW-1:0] angle;
   logic [ROOT_W-1:0]    root;
   logic signed [ZW-1:0] cor_dly_ff [COR_PAD];
   logic [ROOT_W-1:0]    sq_dly_ff [SQ_PAD];

   logic signed [OUT_W-1:0] rsp_re_ff, rsp_im_ff, rsp_re_in, rsp_im_in;
   logic                    rsp_err_ff, rsp_ovf_ff, rsp_err_in, rsp_ovf_in;
   logic                    rsp_valid_ff;
   side_type                side_out;
   sat_type                 sat_r, sat_i;

   function automatic sat_type sat_sum(input logic signed [SUM_W-1:0] v);
      sat_type o;
      if (v > SUM_W'(OUT_MAX)) begin
         o = '{ovf: 1'b1, val: OUT_MAX};
      end else if (v < SUM_W'(OUT_MIN)) begin
         o = '{ovf: 1'b1, val: OUT_MIN};
      end else begin
         o = '{ovf: 1'b0, val: v[OUT_W-1:0]};
      end
      return o;
   endfunction

   function automatic sat_type sat_quo(input logic [NUM_W-1:0] q, input logic neg);
      logic [NUM_W-1:0] lim_neg;
      logic [NUM_W-1:0] lim_pos;
      logic [NUM_W-1:0] nq;
      sat_type          o;
      lim_neg = NUM_W'(unsigned'(OUT_MIN));
      lim_pos = NUM_W'(unsigned'(OUT_MAX));
      nq = -q;
      if (neg) begin
         if (q > lim_neg) o = '{ovf: 1'b1, val: OUT_MIN};
         else o = '{ovf: 1'b0, val: nq[OUT_W-1:0]};
      end else begin
         if (q > lim_pos) o = '{ovf: 1'b1, val: OUT_MAX};
         else o = '{ovf: 1'b0, val: q[OUT_W-1:0]};
      end
      return o;
   endfunction

   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VLD_N; k++) vld_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_ch.valid;
         for (int k = 1; k < VLD_N; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_valid_ff <= vld_ff[VLD_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func1_ff <= req_ch.func;
         ar1_ff <= req_ch.a_real;
         ai1_ff <= req_ch.a_imag;
         br1_ff <= req_ch.b_real;
         bi1_ff <= req_ch.b_imag;

         func2_ff <= func1_ff;
         ar2_ff <= ar1_ff;
         ai2_ff <= ai1_ff;
         br2_ff <= br1_ff;
         bi2_ff <= bi1_ff;
         p_rr_ff <= ar1_ff * br1_ff;
         p_ii_ff <= ai1_ff * bi1_ff;
         p_ri_ff <= ar1_ff * bi1_ff;
         p_ir_ff <= ai1_ff * br1_ff;
         d_r_ff <= br1_ff * br1_ff;
         d_i_ff <= bi1_ff * bi1_ff;
         m_r_ff <= ar1_ff * ar1_ff;
         m_i_ff <= ai1_ff * ai1_ff;
      end
   end

   logic signed [SUM_W-1:0] nr_in, ni_in;
   assign nr_in = SUM_W'(p_rr_ff) + SUM_W'(p_ii_ff);
   assign ni_in = SUM_W'(p_ir_ff) - SUM_W'(p_ri_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         nr3_ff <= nr_in;
         ni3_ff <= ni_in;
         den3_ff <= unsigned'(d_r_ff) + unsigned'(d_i_ff);
         mag3_ff <= unsigned'(m_r_ff) + unsigned'(m_i_ff);
         ar3_ff <= ar2_ff;
         ai3_ff <= ai2_ff;
         side_ff[0].func <= func2_ff;
         side_ff[0].den_zero <= (br2_ff == '0) && (bi2_ff == '0);
         side_ff[0].a_zero <= (ar2_ff == '0) && (ai2_ff == '0);
         side_ff[0].nr_neg <= nr_in[SUM_W-1];
         side_ff[0].ni_neg <= ni_in[SUM_W-1];
         if (func2_ff == FN_SUB) begin
            side_ff[0].as_re <= (IN_W + 1)'(ar2_ff) - (IN_W + 1)'(br2_ff);
            side_ff[0].as_im <= (IN_W + 1)'(ai2_ff) - (IN_W + 1)'(bi2_ff);
         end else begin
            side_ff[0].as_re <= (IN_W + 1)'(ar2_ff) + (IN_W + 1)'(br2_ff);
            side_ff[0].as_im <= (IN_W + 1)'(ai2_ff) + (IN_W + 1)'(bi2_ff);
         end
         side_ff[0].mul_re <= SUM_W'(p_rr_ff) - SUM_W'(p_ii_ff);
         side_ff[0].mul_im <= SUM_W'(p_ri_ff) + SUM_W'(p_ir_ff);
         for (int k = 1; k <= DIV_LAT; k++) side_ff[k] <= side_ff[k-1];

         cor_dly_ff[0] <= angle;
         for (int k = 1; k < COR_PAD; k++) cor_dly_ff[k] <= cor_dly_ff[k-1];
         sq_dly_ff[0] <= root;
         for (int k = 1; k < SQ_PAD; k++) sq_dly_ff[k] <= sq_dly_ff[k-1];
      end
   end

   cna_divider u_div (
      .clock  (clock),
      .en     (adv),
      .num_re (nr3_ff),
      .num_im (ni3_ff),
      .den    (den3_ff),
      .quo_re (quo_re),
      .quo_im (quo_im)
   );

   cna_cordic u_cordic (
      .clock (clock),
      .en    (adv),
      .a_re  (ar3_ff),
      .a_im  (ai3_ff),
      .angle (angle)
   );

   cna_isqrt u_isqrt (
      .clock (clock),
      .en    (adv),
      .mag2  (mag3_ff),
      .root  (root)
   );

   assign side_out = side_ff[DIV_LAT];

   always_comb begin
      rsp_re_in = '0;
      rsp_im_in = '0;
      rsp_err_in = 1'b0;
      rsp_ovf_in = 1'b0;
      sat_r = '0;
      sat_i = '0;
      case (func_type'(side_out.func))
         FN_ADD, FN_SUB: begin
            rsp_re_in = OUT_W'(side_out.as_re) <<< (OUT_FRAC - IN_FRAC);
            rsp_im_in = OUT_W'(side_out.as_im) <<< (OUT_FRAC - IN_FRAC);
         end
         FN_MUL: begin
            sat_r = sat_sum(side_out.mul_re);
            sat_i = sat_sum(side_out.mul_im);
            rsp_re_in = sat_r.val;
            rsp_im_in = sat_i.val;
            rsp_ovf_in = sat_r.ovf || sat_i.ovf;
         end
         FN_DIV: begin
            if (side_out.den_zero) begin
               rsp_err_in = 1'b1;
            end else begin
               sat_r = sat_quo(quo_re, side_out.nr_neg);
               sat_i = sat_quo(quo_im, side_out.ni_neg);
               rsp_re_in = sat_r.val;
               rsp_im_in = sat_i.val;
               rsp_ovf_in = sat_r.ovf || sat_i.ovf;
            end
         end
         FN_ARG: begin
            if (side_out.a_zero) rsp_err_in = 1'b1;
            else rsp_re_in = OUT_W'(cor_dly_ff[COR_PAD-1]);
         end
         FN_MOD: begin
            rsp_re_in = OUT_W'(sq_dly_ff[SQ_PAD-1]);
         end
         default: begin
            rsp_re_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_re_ff <= rsp_re_in;
         rsp_im_ff <= rsp_im_in;
         rsp_err_ff <= rsp_err_in;
         rsp_ovf_ff <= rsp_ovf_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.res_real = rsp_re_ff;
   assign rsp_ch.res_imag = rsp_im_ff;
   assign rsp_ch.div_error = rsp_err_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

endmodule

@@ src/cna_checker.sv @@
// Port-level checks of the complex number ALU and their binding to the top level
`include "complex_number_alu_top_defines.svh"

module cna_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [cna_pkg::OUT_W-1:0] rsp_res_real,
   input logic signed [cna_pkg::OUT_W-1:0] rsp_res_imag,
   input logic                            rsp_div_error,
   input logic                            rsp_overflow
);
   import cna_pkg::*;

   localparam logic signed [OUT_W-1:0] SAT_HI = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] SAT_LO = {1'b1, {(OUT_W-1){1'b0}}};

   `CNA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_res_real) && $stable(rsp_res_imag) && $stable(rsp_div_error) && $stable(rsp_overflow), "stalled response changed")
   `CNA_ASSERT_IMP(a_backpressure, rsp_valid && !rsp_ready, !req_ready, "request taken while output blocked")
   `CNA_ASSERT_IMP(a_err_zero, rsp_valid && rsp_div_error, rsp_res_real == '0 && rsp_res_imag == '0 && !rsp_overflow, "error response not zero")
   `CNA_ASSERT_IMP(a_ovf_bound, rsp_valid && rsp_overflow, rsp_res_real == SAT_HI || rsp_res_real == SAT_LO || rsp_res_imag == SAT_HI || rsp_res_imag == SAT_LO, "overflow without saturated part")

endmodule

bind complex_number_alu_top cna_checker u_cna_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_res_real  (rsp_ch.res_real),
   .rsp_res_imag  (rsp_ch.res_imag),
   .rsp_div_error (rsp_ch.div_error),
   .rsp_overflow  (rsp_ch.overflow)
);

@@ tb/sv/cna_tb_checker.sv @@
// Checker for the complex number ALU: watches both channels, predicts and compares
module cna_tb_checker (
   input  logic clock,
   input  logic reset,
   cna_req_if.sink  req_mon,
   cna_rsp_if.sink  rsp_mon,
   output int       fail_count,
   output int       pending_count,
   output logic     accept_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import cna_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] re;
      logic signed [OUT_W-1:0] im;
      logic                    err;
      logic                    ovf;
   } alu_result_t;

   alu_result_t expected_results[$];

   localparam longint OMAX = (64'sd1 <<< (OUT_W - 1)) - 1;
   localparam longint OMIN = -OMAX - 1;

   function automatic longint clamp_out(input longint v, inout logic ovf);
      if (v > OMAX) begin
         ovf = 1'b1;
         return OMAX;
      end
      if (v < OMIN) begin
         ovf = 1'b1;
         return OMIN;
      end
      return v;
   endfunction

   // rescale from 'f' fraction bits to the output format
   function automatic longint rescale(input longint v, input int f, inout logic ovf);
      longint lim;
      if (OUT_FRAC >= f) begin
         lim = OMAX >>> (OUT_FRAC - f);
         if (v > lim) begin
            ovf = 1'b1;
            return OMAX;
         end
         if (v < -lim - 1) begin
            ovf = 1'b1;
            return OMIN;
         end
         return clamp_out(v <<< (OUT_FRAC - f), ovf);
      end
      return clamp_out(v >>> (f - OUT_FRAC), ovf);
   endfunction

   function automatic longint int_sqrt(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint vector_angle(input longint xr, input longint yi);
      longint x, y, z, t, dx, dy;
      longint tbl[16];
      tbl = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
              256, 128, 64, 32, 16, 8, 4, 2};
      x = xr * 65536;
      y = yi * 65536;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = 102944;
         end else begin
            x = -y;
            y = t;
            z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            z += tbl[i];
         end else begin
            x -= dx;
            y += dy;
            z -= tbl[i];
         end
      end
      return z;
   endfunction

   function automatic alu_result_t compute_result(input logic [2:0] fn,
         input longint ar, input longint ai, input longint br, input longint bi);
      alu_result_t r;
      longint rr, ri, den, nr, ni;
      logic err, ovf;
      rr = 0;
      ri = 0;
      err = 1'b0;
      ovf = 1'b0;
      case (fn)
         FN_ADD: begin
            rr = rescale(ar + br, IN_FRAC, ovf);
            ri = rescale(ai + bi, IN_FRAC, ovf);
         end
         FN_SUB: begin
            rr = rescale(ar - br, IN_FRAC, ovf);
            ri = rescale(ai - bi, IN_FRAC, ovf);
         end
         FN_MUL: begin
            rr = rescale(ar * br - ai * bi, 2 * IN_FRAC, ovf);
            ri = rescale(ar * bi + ai * br, 2 * IN_FRAC, ovf);
         end
         FN_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               err = 1'b1;
            end else begin
               nr = ar * br + ai * bi;
               ni = br * ai - bi * ar;
               rr = clamp_out((nr <<< OUT_FRAC) / den, ovf);
               ri = clamp_out((ni <<< OUT_FRAC) / den, ovf);
            end
         end
         FN_ARG: begin
            if (ar == 0 && ai == 0) err = 1'b1;
            else rr = rescale(vector_angle(ar, ai), 16, ovf);
         end
         FN_MOD: begin
            rr = clamp_out(int_sqrt(longint'(ar * ar + ai * ai) << (2 * (OUT_FRAC - IN_FRAC))),
                           ovf);
         end
         default: ;
      endcase
      r.re = rr[OUT_W-1:0];
      r.im = ri[OUT_W-1:0];
      r.err = err;
      r.ovf = ovf;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always_comb accept_seen = (req_mon.valid && req_mon.ready) ||
                             (rsp_mon.valid && rsp_mon.ready);

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      alu_result_t want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(compute_result(req_mon.func,
               longint'(req_mon.a_real), longint'(req_mon.a_imag),
               longint'(req_mon.b_real), longint'(req_mon.b_imag)));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.res_real !== want.re)
                  report_mismatch("res_real", rsp_mon.res_real, want.re);
               if (rsp_mon.res_imag !== want.im)
                  report_mismatch("res_imag", rsp_mon.res_imag, want.im);
               if (rsp_mon.div_error !== want.err)
                  report_mismatch("div_error", rsp_mon.div_error, want.err);
               if (rsp_mon.overflow !== want.ovf)
                  report_mismatch("overflow", rsp_mon.overflow, want.ovf);
            end
         end
      end
      pending_count = expected_results.size();
   end
endmodule

@@ tb/sv/tb_complex_number_alu_top.sv @@
// Testbench top for the complex number ALU: clock, reset, stimulus and verdict
module tb_complex_number_alu_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cna_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   logic accept_seen;
   logic hold_rsp = 1'b0;
   int   idle_cycles = 0;

   cna_req_if req_ch ();
   cna_rsp_if rsp_ch ();

   complex_number_alu_top uut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));

   cna_tb_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count), .accept_seen(accept_seen)
   );

   always #10 clock = ~clock;

   task automatic wait_cycles(input int n);
      repeat (n) @(negedge clock);
   endtask

   // valid stays high after the request is taken; the caller drops it when done
   task automatic send_request(input logic [2:0] fn, input logic [15:0] ar, input logic [15:0] ai,
                               input logic [15:0] br, input logic [15:0] bi, input bit gaps);
      int gap_n;
      gap_n = gaps ? $urandom_range(0, 15) : 0;
      if (gap_n > 0) begin
         req_ch.valid <= 1'b0;
         wait_cycles(gap_n);
      end
      req_ch.valid  <= 1'b1;
      req_ch.func   <= fn;
      req_ch.a_real <= ar;
      req_ch.a_imag <= ai;
      req_ch.b_real <= br;
      req_ch.b_imag <= bi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // response side: random stall per request, with stall-free stretches and a long hold
   initial begin
      int wait_n;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            wait_cycles(1);
         end else begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (wait_n > 0) begin
               rsp_ch.ready <= 1'b0;
               wait_cycles(wait_n);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
            while (!rsp_ch.valid) @(posedge clock);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || accept_seen) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [2:0] fn;
      req_ch.valid = 1'b0;
      req_ch.func = FN_ADD;
      req_ch.a_real = '0;
      req_ch.a_imag = '0;
      req_ch.b_real = '0;
      req_ch.b_imag = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, each operation, divide by zero, argument of zero, bad selector
      for (int f = 0; f < 6; f++) begin
         send_request(f[2:0], 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0);
         send_request(f[2:0], 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
      end
      send_request(FN_DIV, 16'h0100, 16'hFF00, 16'h0000, 16'h0000, 0);
      send_request(FN_DIV, 16'h0001, 16'h7FFF, 16'h0001, 16'h0000, 0);
      send_request(FN_ARG, 16'h0000, 16'h0000, 16'h1234, 16'h4321, 0);
      send_request(FN_ARG, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 0);
      send_request(FN_ARG, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 0);
      send_request(FN_ARG, 16'h0000, 16'hFF00, 16'h0000, 16'h0000, 0);
      send_request(FN_MOD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
      send_request(3'd6, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0);
      send_request(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);

      // long output hold while requests keep coming, so the pipeline backs up
      fork
         begin
            hold_rsp <= 1'b1;
            wait_cycles(HOLD_CYCLES);
            hold_rsp <= 1'b0;
         end
         for (int i = 0; i < 80; i++)
            send_request(3'($urandom_range(0, 5)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand(), 0);
      join
      req_ch.valid <= 1'b0;

      // pause until drained
      while (pending_count != 0) @(negedge clock);

      for (int i = 0; i < 320; i++) begin
         fn = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
         send_request(fn, pick_operand(), pick_operand(), pick_operand(), pick_operand(),
                      ($urandom_range(0, 3) != 0));
      end
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      wait_cycles(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
